@@ sv/lrcs_pkg.sv @@
// Shared types, constants and tables of the lidar row-centering steering block.
`timescale 1ns / 1ps
package lrcs_pkg;

  localparam int unsigned NUM_BEAMS   = 270;
  localparam int unsigned SUM_W       = 37;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned DVD_W       = 56;
  localparam int unsigned DEN_W       = 39;
  localparam int unsigned MCAND_W     = 54;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned STEER_W     = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [STEER_W-1:0] LIMIT_Q14 = 15'd14746;
  localparam logic [STEER_W-1:0] DEAD_Q14  = 15'd819;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd5;

  // Divider operand select
  typedef enum logic [1:0] {
    DSEL_LEFT,
    DSEL_RIGHT,
    DSEL_RATIO
  } div_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     product;
    logic     accum;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     setup;
    logic     mul_step;
    logic     finish;
  } lrcs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic enable;
    logic eos;
    logic div_last;
    logic mul_last;
  } lrcs_status_t;

  // Q1.15 cosine of 0..90 degrees
  function automatic logic [15:0] cos_lookup(input logic [6:0] a);
    logic [15:0] c;
    case (a)
      7'd0: c = 16'd32768;  7'd1: c = 16'd32763;  7'd2: c = 16'd32748;
      7'd3: c = 16'd32723;  7'd4: c = 16'd32688;  7'd5: c = 16'd32643;
      7'd6: c = 16'd32588;  7'd7: c = 16'd32524;  7'd8: c = 16'd32449;
      7'd9: c = 16'd32365;  7'd10: c = 16'd32270; 7'd11: c = 16'd32166;
      7'd12: c = 16'd32052; 7'd13: c = 16'd31928; 7'd14: c = 16'd31795;
      7'd15: c = 16'd31651; 7'd16: c = 16'd31499; 7'd17: c = 16'd31336;
      7'd18: c = 16'd31164; 7'd19: c = 16'd30983; 7'd20: c = 16'd30792;
      7'd21: c = 16'd30592; 7'd22: c = 16'd30382; 7'd23: c = 16'd30163;
      7'd24: c = 16'd29935; 7'd25: c = 16'd29698; 7'd26: c = 16'd29452;
      7'd27: c = 16'd29197; 7'd28: c = 16'd28932; 7'd29: c = 16'd28660;
      7'd30: c = 16'd28378; 7'd31: c = 16'd28088; 7'd32: c = 16'd27789;
      7'd33: c = 16'd27482; 7'd34: c = 16'd27166; 7'd35: c = 16'd26842;
      7'd36: c = 16'd26510; 7'd37: c = 16'd26170; 7'd38: c = 16'd25822;
      7'd39: c = 16'd25466; 7'd40: c = 16'd25102; 7'd41: c = 16'd24730;
      7'd42: c = 16'd24351; 7'd43: c = 16'd23965; 7'd44: c = 16'd23571;
      7'd45: c = 16'd23170; 7'd46: c = 16'd22763; 7'd47: c = 16'd22348;
      7'd48: c = 16'd21926; 7'd49: c = 16'd21498; 7'd50: c = 16'd21063;
      7'd51: c = 16'd20622; 7'd52: c = 16'd20174; 7'd53: c = 16'd19720;
      7'd54: c = 16'd19261; 7'd55: c = 16'd18795; 7'd56: c = 16'd18324;
      7'd57: c = 16'd17847; 7'd58: c = 16'd17364; 7'd59: c = 16'd16877;
      7'd60: c = 16'd16384; 7'd61: c = 16'd15886; 7'd62: c = 16'd15384;
      7'd63: c = 16'd14876; 7'd64: c = 16'd14365; 7'd65: c = 16'd13848;
      7'd66: c = 16'd13328; 7'd67: c = 16'd12803; 7'd68: c = 16'd12275;
      7'd69: c = 16'd11743; 7'd70: c = 16'd11207; 7'd71: c = 16'd10668;
      7'd72: c = 16'd10126; 7'd73: c = 16'd9580;  7'd74: c = 16'd9032;
      7'd75: c = 16'd8481;  7'd76: c = 16'd7927;  7'd77: c = 16'd7371;
      7'd78: c = 16'd6813;  7'd79: c = 16'd6252;  7'd80: c = 16'd5690;
      7'd81: c = 16'd5126;  7'd82: c = 16'd4560;  7'd83: c = 16'd3993;
      7'd84: c = 16'd3425;  7'd85: c = 16'd2856;  7'd86: c = 16'd2286;
      7'd87: c = 16'd1715;  7'd88: c = 16'd1144;  7'd89: c = 16'd572;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

  // Snap a magnitude up to the next grid step (0.1, 0.15, then 0.1 steps to 0.9), small values kept
  function automatic logic [STEER_W-1:0] quant_mag(input logic [STEER_W-1:0] m);
    logic [STEER_W-1:0] r;
    if (m <= DEAD_Q14)       r = m;
    else if (m < 15'd1638)   r = 15'd1638;
    else if (m < 15'd2458)   r = 15'd2458;
    else if (m < 15'd3277)   r = 15'd3277;
    else if (m < 15'd4915)   r = 15'd4915;
    else if (m < 15'd6554)   r = 15'd6554;
    else if (m < 15'd8192)   r = 15'd8192;
    else if (m < 15'd9830)   r = 15'd9830;
    else if (m < 15'd11469)  r = 15'd11469;
    else if (m < 15'd13107)  r = 15'd13107;
    else                     r = LIMIT_Q14;
    return r;
  endfunction

endpackage

@@ sv/lrcs_ctrl.sv @@
// Sequencer for beam accumulation and the end-of-scan divide/multiply steps.
`timescale 1ns / 1ps
module lrcs_ctrl import lrcs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  lrcs_status_t status,
  output lrcs_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_LLOAD, ST_LRUN, ST_RLOAD, ST_RRUN,
    ST_SETUP, ST_MRUN, ST_QLOAD, ST_QRUN, ST_FIN
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.div_sel = DSEL_LEFT;
    case (state)
      ST_IDLE: begin
        if (start && status.enable) begin
          cmd.capture = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.product = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_next = status.eos ? ST_LLOAD : ST_IDLE;
      end
      ST_LLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel = DSEL_LEFT;
        state_next = ST_LRUN;
      end
      ST_LRUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_RLOAD;
      end
      ST_RLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel = DSEL_RIGHT;
        state_next = ST_RRUN;
      end
      ST_RRUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = ST_MRUN;
      end
      ST_MRUN: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = ST_QLOAD;
      end
      ST_QLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel = DSEL_RATIO;
        state_next = ST_QRUN;
      end
      ST_QRUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/lrcs_dp.sv @@
// Datapath: config registers, window sums, shared divider and serial multiplier.
`timescale 1ns / 1ps
module lrcs_dp import lrcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lrcs_cmd_t               cmd,
  output lrcs_status_t            status,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [8:0]              beam_index,
  input  logic [15:0]             beam_range,
  input  logic                    end_of_scan,
  output logic                    done,
  output logic signed [STEER_W-1:0] steering,
  output logic                    stop,
  output logic                    left_seen,
  output logic                    right_seen
);

  localparam int unsigned DCNT_W = $clog2(DVD_W);
  localparam int unsigned MCNT_W = $clog2(GAIN_W);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {MODE_RATIO, MODE_FIXED, MODE_HELD} mode_t;

  // Configuration
  logic        enable;
  logic [15:0] min_range, max_range, lane_half_width;
  logic [5:0]  window_width;
  logic signed [GAIN_W-1:0] steer_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      min_range       <= 16'd205;
      max_range       <= 16'd2458;
      window_width    <= 6'd30;
      steer_gain      <= 16'sd410;
      lane_half_width <= 16'd3072;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:    enable          <= cfg_data[0];
        REG_MIN_RANGE: min_range       <= cfg_data;
        REG_MAX_RANGE: max_range       <= cfg_data;
        REG_WINDOW:    window_width    <= cfg_data[5:0];
        REG_GAIN:      steer_gain      <= $signed(cfg_data);
        REG_HALF:      lane_half_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window membership and cosine lookup
  logic [9:0] idx, w;
  logic in_band, lp, lf, rp, rf;
  logic [9:0] ang_l, ang_r;
  assign idx = {1'b0, beam_index};
  assign w   = {4'd0, window_width};
  assign in_band = (idx < 10'(NUM_BEAMS)) && (beam_range > min_range)
                   && (beam_range < max_range);
  assign lp = in_band && idx >= 10'd60 && idx <= 10'd60 + w;
  assign lf = in_band && idx >= 10'd75 && idx <= 10'd75 + w && idx <= 10'd134;
  assign rp = in_band && idx <= 10'd210 && idx + w >= 10'd210;
  assign rf = in_band && idx <= 10'd195 && idx >= 10'd136 && idx + w >= 10'd195;
  assign ang_l = idx - 10'd45;
  assign ang_r = 10'd225 - idx;

  logic [15:0] b_range, b_cos_l, b_cos_r;
  logic [3:0]  b_hit;
  logic        b_eos;
  logic [31:0] prod_l, prod_r;

  // Capture the word, then multiply
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_range <= beam_range;
      b_cos_l <= cos_lookup(ang_l[6:0]);
      b_cos_r <= cos_lookup(ang_r[6:0]);
      b_hit   <= {rf, rp, lf, lp};
    end
    if (cmd.product) begin
      prod_l <= 32'(b_range) * 32'(b_cos_l);
      prod_r <= 32'(b_range) * 32'(b_cos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_eos <= 1'b0;
    end else if (cmd.capture) begin
      b_eos <= end_of_scan;
    end
  end

  // Window sums: 0 left primary, 1 left fallback, 2 right primary, 3 right fallback
  logic [SUM_W-1:0] sum [4];
  logic [CNT_W-1:0] cnt [4];

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [31:0] p);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {{(SUM_W-31){1'b0}}, p};
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < 4; i++) begin
        sum[i] <= '0;
        cnt[i] <= '0;
      end
    end else if (cmd.accum) begin
      for (int i = 0; i < 4; i++) begin
        if (b_hit[i]) begin
          sum[i] <= sat_add(sum[i], (i < 2) ? prod_l : prod_r);
          if (cnt[i] != CNT_MAX) cnt[i] <= cnt[i] + 1'b1;
        end
      end
    end
  end

  // Side operands for the mean divide
  logic [CNT_W:0]   tot_l, tot_r;
  logic [SUM_W:0]   comb_l, comb_r;
  logic             seen_l_c, seen_r_c, any_beam;
  assign tot_l = {1'b0, cnt[0]} + {1'b0, cnt[1]};
  assign tot_r = {1'b0, cnt[2]} + {1'b0, cnt[3]};
  assign comb_l = {1'b0, sum[0]} + {1'b0, sum[1]};
  assign comb_r = {1'b0, sum[2]} + {1'b0, sum[3]};
  assign seen_l_c = tot_l >= 8'd2;
  assign seen_r_c = tot_r >= 8'd2;
  assign any_beam = (tot_l != '0) || (tot_r != '0);

  // Shared restoring divider; quotient shifts into the dividend register
  logic [DVD_W-1:0]  dvd;
  logic [DEN_W-1:0]  den, rem, ratio_den;
  logic [DCNT_W-1:0] dcnt;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic [MCAND_W-1:0] mcand, macc;
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= '0;
      dcnt <= DCNT_W'(DVD_W - 1);
      case (cmd.div_sel)
        DSEL_LEFT: begin
          dvd <= (cnt[0] >= 7'd2) ? DVD_W'({1'b0, sum[0]}) : DVD_W'(comb_l);
          den <= (cnt[0] >= 7'd2) ? DEN_W'(cnt[0]) : DEN_W'(tot_l);
        end
        DSEL_RIGHT: begin
          dvd <= (cnt[2] >= 7'd2) ? DVD_W'({1'b0, sum[2]}) : DVD_W'(comb_r);
          den <= (cnt[2] >= 7'd2) ? DEN_W'(cnt[2]) : DEN_W'(tot_r);
        end
        default: begin
          dvd <= {macc[DVD_W-3:0], 2'b00};
          den <= ratio_den;
        end
      endcase
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (!rem_sub[DEN_W]) begin
        rem <= rem_sub[DEN_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Capture the left mean when the right divide starts
  logic [SUM_W-1:0] lmean;
  logic             l_seen, r_seen;
  always_ff @(posedge clk) begin
    if (cmd.div_load && cmd.div_sel == DSEL_RIGHT) begin
      lmean  <= dvd[SUM_W-1:0];
      l_seen <= seen_l_c;
      r_seen <= seen_r_c;
    end
  end

  // Pick the steering case and ratio operands
  logic signed [DEN_W:0] lm_s, rm_s, half_s, inv_s, num_s, sum_lr;
  logic [MCNT_W-1:0] mcnt;
  logic [GAIN_W-1:0] gmag;
  logic              neg, ratio_zero, stop_r;
  mode_t             mode;
  logic signed [STEER_W-1:0] fixed_val;

  assign lm_s   = l_seen ? $signed({{(DEN_W-SUM_W+1){1'b0}}, lmean}) : '0;
  assign rm_s   = r_seen ? $signed({{(DEN_W-SUM_W+1){1'b0}}, dvd[SUM_W-1:0]}) : '0;
  assign half_s = $signed({{(DEN_W-30){1'b0}}, lane_half_width, 15'd0});
  assign sum_lr = lm_s + rm_s;
  assign inv_s  = l_seen ? half_s - lm_s : half_s - rm_s;
  assign num_s  = (l_seen && r_seen) ? lm_s - rm_s :
                  r_seen ? inv_s - rm_s : lm_s - inv_s;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      stop_r     <= !any_beam;
      neg        <= num_s[DEN_W] ^ steer_gain[GAIN_W-1];
      mcand      <= MCAND_W'(num_s[DEN_W] ? -num_s : num_s);
      gmag       <= steer_gain[GAIN_W-1] ? -steer_gain : steer_gain;
      macc       <= '0;
      mcnt       <= MCNT_W'(GAIN_W - 1);
      ratio_den  <= (l_seen && r_seen) ? sum_lr[DEN_W-1:0] : half_s[DEN_W-1:0];
      ratio_zero <= (l_seen && r_seen) ? (sum_lr == '0) : (half_s == '0);
      fixed_val  <= r_seen ? -$signed(LIMIT_Q14) : $signed(LIMIT_Q14);
      if (!l_seen && !r_seen)     mode <= MODE_HELD;
      else if (l_seen && r_seen)  mode <= MODE_RATIO;
      else if (inv_s[DEN_W])      mode <= MODE_FIXED;
      else                        mode <= MODE_RATIO;
    end else if (cmd.mul_step) begin
      // Shift-add over the gain magnitude, least significant bit first
      mcnt  <= mcnt - 1'b1;
      gmag  <= gmag >> 1;
      mcand <= mcand << 1;
      if (gmag[0]) macc <= macc + mcand;
    end
  end

  // Clamp, quantize and drive the result word
  logic [STEER_W-1:0]        rmag, qmag, vmag;
  logic signed [STEER_W-1:0] ratio_v, val, qval, held;
  assign rmag    = (dvd > DVD_W'(LIMIT_Q14)) ? LIMIT_Q14 : dvd[STEER_W-1:0];
  assign ratio_v = ratio_zero ? '0 : (neg ? -$signed(rmag) : $signed(rmag));
  assign val     = (mode == MODE_RATIO) ? ratio_v :
                   (mode == MODE_FIXED) ? fixed_val : held;
  assign vmag    = val[STEER_W-1] ? STEER_W'(-val) : val;
  assign qmag    = quant_mag(vmag);
  assign qval    = val[STEER_W-1] ? -$signed(qmag) : $signed(qmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish && !stop_r) held <= qval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      steering   <= stop_r ? '0 : qval;
      stop       <= stop_r;
      left_seen  <= !stop_r && l_seen;
      right_seen <= !stop_r && r_seen;
    end
  end

  assign status.enable   = enable;
  assign status.eos      = b_eos;
  assign status.div_last = (dcnt == '0);
  assign status.mul_last = (mcnt == '0);

endmodule

@@ sv/lidar_row_centering_steer.sv @@
// Top level of the lidar row-centering steering block.
//
// Beams arrive as words on start/busy: a word (beam_index, beam_range,
// end_of_scan) is taken at a clock edge with start high and busy low.
// While enable is 0 words are taken and dropped. An ordinary beam passes
// through capture, 16x16 cosine multiply and saturating accumulate. A
// beam with end_of_scan set then runs two 56-step restoring divides for
// the side means, a 16-step shift-add multiply by the gain and one more
// 56-step divide for the ratio, with a load state before each divide, a
// setup state before the multiply and a finish state at the end.
// One result word per enabled scan appears on steering/stop/left_seen/
// right_seen with done high for exactly one cycle, the cycle after finish,
// when busy is already low; the receiver cannot stall it. Configuration
// writes go through cfg_valid/cfg_ready (always ready); the user must make
// them while the block is idle, which the block itself does not enforce.
// Synchronous reset rst clears the sums, the held command and loads the
// default register values.
`timescale 1ns / 1ps
module lidar_row_centering_steer import lrcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [8:0]                beam_index,
  input  logic [15:0]               beam_range,
  input  logic                      end_of_scan,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic                      done,
  output logic signed [STEER_W-1:0] steering,
  output logic                      stop,
  output logic                      left_seen,
  output logic                      right_seen
);

  lrcs_cmd_t    cmd;
  lrcs_status_t status;

  assign cfg_ready = 1'b1;

  lrcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lrcs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .beam_index  (beam_index),
    .beam_range  (beam_range),
    .end_of_scan (end_of_scan),
    .done        (done),
    .steering    (steering),
    .stop        (stop),
    .left_seen   (left_seen),
    .right_seen  (right_seen)
  );

endmodule

@@ sv/lrcs_checker.sv @@
// Port-level checks of the steering block, bound to the top level.
`timescale 1ns / 1ps
module lrcs_checker import lrcs_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [STEER_W-1:0] steering,
  input logic                      stop,
  input logic                      left_seen,
  input logic                      right_seen
);

  // A stop word carries a zero command and no seen flags
  a_stop_clean: assert property (@(posedge clk) disable iff (rst)
    done && stop |-> steering == '0 && !left_seen && !right_seen)
    else $error("stop word with command or seen flags");

  // The command stays within the limit
  a_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> steering <= $signed(LIMIT_Q14) && steering >= -$signed(LIMIT_Q14))
    else $error("steering beyond limit");

  // The block only gets busy after a word was offered
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("block became busy without a word");

  // A result word shows while the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  // Two result words never come back to back
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result words");

endmodule

bind lidar_row_centering_steer lrcs_checker u_lrcs_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .steering   (steering),
  .stop       (stop),
  .left_seen  (left_seen),
  .right_seen (right_seen)
);
